// ===== hdl/kpclk_pkg.sv =====
// shared types, constants and digit helpers for the keypad-set minutes:seconds clock
// no dependencies; imported by the input interface, the state core and the top level
`default_nettype none

package kpclk_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned KEY_W  = 4;
  localparam int unsigned LAST_W = 5;

  localparam logic [TICK_W-1:0] TPS_RESET   = 16'd20;
  localparam logic [LAST_W-1:0] LAST_NONE   = 5'd16;

  // opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  // key codes
  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_TIME_ON   = 4'd10;
  localparam logic [KEY_W-1:0] KEY_TIME_OFF  = 4'd11;
  localparam logic [KEY_W-1:0] KEY_ALARM_ON  = 4'd12;
  localparam logic [KEY_W-1:0] KEY_ALARM_OFF = 4'd13;

  // digit limits
  localparam logic [3:0] UNITS_MAX = 4'd9;
  localparam logic [2:0] TENS_MAX  = 3'd5;

  // entry positions
  localparam logic [1:0] POS_MIN_TENS  = 2'd0;
  localparam logic [1:0] POS_MIN_UNITS = 2'd1;
  localparam logic [1:0] POS_SEC_TENS  = 2'd2;
  localparam logic [1:0] POS_SEC_UNITS = 2'd3;

  typedef struct packed {
    logic [3:0] d0;  // minutes tens
    logic [3:0] d1;  // minutes units
    logic [2:0] d2;  // seconds tens
    logic [3:0] d3;  // seconds units
  } digits_t;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key_code;
  } item_t;

  typedef struct packed {
    digits_t shown;
    logic    time_setting_on;
    logic    alarm_setting_on;
  } result_t;

  function automatic digits_t put_digit(digits_t d, logic [1:0] pos, logic [KEY_W-1:0] key);
    digits_t r;
    r = d;
    case (pos)
      POS_MIN_TENS:  r.d0 = key;
      POS_MIN_UNITS: r.d1 = key;
      POS_SEC_TENS:  r.d2 = (key > {1'b0, TENS_MAX}) ? TENS_MAX : key[2:0];
      POS_SEC_UNITS: r.d3 = key;
      default:       r = d;
    endcase
    return r;
  endfunction

  // one second forward, carries 9, 5, 9, 9
  function automatic digits_t advance(digits_t d);
    digits_t r;
    r = d;
    if (d.d3 < UNITS_MAX) begin
      r.d3 = d.d3 + 4'd1;
    end else begin
      r.d3 = '0;
      if (d.d2 < TENS_MAX) begin
        r.d2 = d.d2 + 3'd1;
      end else begin
        r.d2 = '0;
        if (d.d1 < UNITS_MAX) begin
          r.d1 = d.d1 + 4'd1;
        end else begin
          r.d1 = '0;
          r.d0 = (d.d0 < UNITS_MAX) ? d.d0 + 4'd1 : 4'd0;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kpclk_in_if.sv =====
// input channel: valid/ready handshake carrying one tick or key beat
// depends on kpclk_pkg for the key width
`default_nettype none

interface kpclk_in_if;
  import kpclk_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, output opcode, output key_code, input ready);
  modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

`default_nettype wire

// ===== hdl/kpclk_out_if.sv =====
// output channel: valid/ready handshake carrying the shown digits and mode flags
// no dependencies
`default_nettype none

interface kpclk_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] shown_digit_0;
  logic [3:0] shown_digit_1;
  logic [2:0] shown_digit_2;
  logic [3:0] shown_digit_3;
  logic       time_setting_on;
  logic       alarm_setting_on;

  modport source (output valid, output shown_digit_0, output shown_digit_1,
                  output shown_digit_2, output shown_digit_3,
                  output time_setting_on, output alarm_setting_on, input ready);
  modport sink   (input valid, input shown_digit_0, input shown_digit_1,
                  input shown_digit_2, input shown_digit_3,
                  input time_setting_on, input alarm_setting_on, output ready);
endinterface

`default_nettype wire

// ===== hdl/kpclk_core.sv =====
// clock state: digits, alarm digits, entry position, modes, prescaler and threshold
// updates on each stepped item and presents the result for it; uses kpclk_pkg
`default_nettype none

module kpclk_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [kpclk_pkg::TICK_W-1:0]  cfg_wr_data,
  input  wire logic                          step_en,
  input  wire kpclk_pkg::item_t              item,
  output      kpclk_pkg::result_t            result
);
  import kpclk_pkg::*;

  logic [TICK_W-1:0] ticks_per_second;
  digits_t           time_digits,    time_digits_next;
  digits_t           alarm_digits,   alarm_digits_next;
  logic [1:0]        entry_pos,      entry_pos_next;
  logic [LAST_W-1:0] last_key,       last_key_next;
  logic              time_mode,      time_mode_next;
  logic              alarm_mode,     alarm_mode_next;
  logic [TICK_W-1:0] tick_count,     tick_count_next;

  always_comb begin
    time_digits_next  = time_digits;
    alarm_digits_next = alarm_digits;
    entry_pos_next    = entry_pos;
    last_key_next     = last_key;
    time_mode_next    = time_mode;
    alarm_mode_next   = alarm_mode;
    tick_count_next   = tick_count;

    if (item.opcode == OP_TICK) begin
      if (tick_count != '1) begin
        tick_count_next = tick_count + TICK_W'(1);
      end
    end else if ({1'b0, item.key_code} != last_key) begin
      last_key_next = {1'b0, item.key_code};
      case (item.key_code)
        KEY_TIME_ON:   time_mode_next  = 1'b1;
        KEY_TIME_OFF:  time_mode_next  = 1'b0;
        KEY_ALARM_ON:  alarm_mode_next = 1'b1;
        KEY_ALARM_OFF: alarm_mode_next = 1'b0;
        default:       ;
      endcase
      if (item.key_code <= KEY_DIGIT_MAX) begin
        // both modes on: time at pos, alarm at pos+1
        if (time_mode) begin
          time_digits_next = put_digit(time_digits, entry_pos_next, item.key_code);
          entry_pos_next   = entry_pos_next + 2'd1;
        end
        if (alarm_mode) begin
          alarm_digits_next = put_digit(alarm_digits, entry_pos_next, item.key_code);
          entry_pos_next    = entry_pos_next + 2'd1;
        end
      end
    end

    if (!time_mode_next && !alarm_mode_next && tick_count_next >= ticks_per_second) begin
      tick_count_next  = '0;
      time_digits_next = advance(time_digits_next);
    end
  end

  always_comb begin
    result.shown = (alarm_mode_next && !time_mode_next) ? alarm_digits_next
                                                        : time_digits_next;
    result.time_setting_on  = time_mode_next;
    result.alarm_setting_on = alarm_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_digits  <= '0;
      alarm_digits <= '0;
      entry_pos    <= '0;
      last_key     <= LAST_NONE;
      time_mode    <= 1'b0;
      alarm_mode   <= 1'b0;
      tick_count   <= '0;
    end else if (step_en) begin
      time_digits  <= time_digits_next;
      alarm_digits <= alarm_digits_next;
      entry_pos    <= entry_pos_next;
      last_key     <= last_key_next;
      time_mode    <= time_mode_next;
      alarm_mode   <= alarm_mode_next;
      tick_count   <= tick_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/keypad_set_minute_second_clock.sv =====
// top level of the keypad-set minutes:seconds clock: input register, state core, result register
// depends on kpclk_pkg, kpclk_in_if, kpclk_out_if and kpclk_core
// path: an accepted beat goes to the input register, then steps through the core into the result register
// throughput: one beat per cycle, limited only by the result register draining
// the state update is one short combinational pass in kpclk_core between the two registers
// reset: synchronous, clears digits, modes, prescaler, entry position, last key
// and both pipeline valids; the threshold returns to 20 ticks
`default_nettype none

module keypad_set_minute_second_clock (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [kpclk_pkg::TICK_W-1:0]  cfg_wr_data,
  kpclk_in_if.sink                           cmd,
  kpclk_out_if.source                        disp
);
  import kpclk_pkg::*;

  // input register stage
  logic    s1_valid;
  item_t   s1_item;

  // result register stage
  logic    out_valid;
  result_t out_data;

  // core result for the item in the input register
  result_t core_result;

  // result register can take a new beat when empty or being drained
  logic    out_load_ok;
  logic    step_en;
  logic    in_take;

  assign out_load_ok = !out_valid || disp.ready;
  // the item in the input register commits its state change as it moves on
  assign step_en     = s1_valid && out_load_ok;
  // input register refills whenever it empties in the same cycle, so no bubble
  assign in_take     = cmd.valid && cmd.ready;
  assign cmd.ready   = !s1_valid || out_load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.opcode   <= cmd.opcode;
      s1_item.key_code <= cmd.key_code;
    end
  end

  kpclk_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_en),
    .item        (s1_item),
    .result      (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load_ok) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= core_result;
    end
  end

  // result beat onto the output channel
  assign disp.valid            = out_valid;
  assign disp.shown_digit_0    = out_data.shown.d0;
  assign disp.shown_digit_1    = out_data.shown.d1;
  assign disp.shown_digit_2    = out_data.shown.d2;
  assign disp.shown_digit_3    = out_data.shown.d3;
  assign disp.time_setting_on  = out_data.time_setting_on;
  assign disp.alarm_setting_on = out_data.alarm_setting_on;

  // input stalls only while a beat is parked in the input register
  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> s1_valid)
    else $error("input stalled with empty input register");

  // a beat that moves on always lands in the result register
  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    step_en |=> out_valid)
    else $error("stepped beat lost before result register");

  // shown digits stay decimal
  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (disp.shown_digit_0 <= UNITS_MAX && disp.shown_digit_1 <= UNITS_MAX &&
                   disp.shown_digit_2 <= TENS_MAX && disp.shown_digit_3 <= UNITS_MAX))
    else $error("shown digit out of range");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== verif/keypad_set_minute_second_clock_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the keypad-set minutes:seconds clock, random stalls on both channels
// depends on kpclk_pkg, kpclk_in_if, kpclk_out_if and keypad_set_minute_second_clock

module keypad_set_minute_second_clock_tb;
  import kpclk_pkg::*;

  // keys 14 and 15 only update the last-key memory
  localparam logic [KEY_W-1:0] KEY_SPARE_A = 4'd14;
  localparam logic [KEY_W-1:0] KEY_SPARE_B = 4'd15;
  localparam int QUIET_LIMIT     = 5000;
  localparam int BEATS_PER_PHASE = 225;
  localparam int HELD_TICKS      = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [TICK_W-1:0] cfg_wr_data = '0;

  kpclk_in_if  cmd_if ();
  kpclk_out_if disp_if ();

  keypad_set_minute_second_clock u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_if),
    .disp        (disp_if)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // clock state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] thresh = TPS_RESET;
  logic [TICK_W-1:0] tick_cnt = '0;
  logic [3:0]        time_dig [4] = '{4'd0, 4'd0, 4'd0, 4'd0};
  logic [3:0]        alarm_dig [4] = '{4'd0, 4'd0, 4'd0, 4'd0};
  logic [1:0]        entry_pos = POS_MIN_TENS;
  logic [LAST_W-1:0] last_key = LAST_NONE;
  logic              time_mode = 1'b0;
  logic              alarm_mode = 1'b0;

  item_t   beat_q [$];         // beats waiting to be driven
  result_t display_due_q [$];  // display beats the clock owes us, oldest first
  int      beats_queued = 0;
  int      results_checked = 0;
  int      mismatches = 0;

  // seconds tens can hold at most 5
  function automatic logic [3:0] entry_value(logic [1:0] pos, logic [KEY_W-1:0] key);
    if (pos == POS_SEC_TENS && key > {1'b0, TENS_MAX}) begin
      return {1'b0, TENS_MAX};
    end
    return key;
  endfunction

  // apply one beat to the clock state and return what the display shows after it
  function automatic result_t step_clock(item_t beat);
    result_t    r;
    logic [3:0] shown [4];
    if (beat.opcode == OP_TICK) begin
      // prescaler saturates instead of wrapping
      if (tick_cnt != '1) begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end else if ({1'b0, beat.key_code} != last_key) begin
      // a key held or pressed again is dropped entirely
      last_key = {1'b0, beat.key_code};
      case (beat.key_code)
        KEY_TIME_ON:   time_mode = 1'b1;
        KEY_TIME_OFF:  time_mode = 1'b0;
        KEY_ALARM_ON:  alarm_mode = 1'b1;
        KEY_ALARM_OFF: alarm_mode = 1'b0;
        default: ;
      endcase
      if (beat.key_code <= KEY_DIGIT_MAX) begin
        // with both modes on the key lands in time, then in alarm one slot further
        if (time_mode) begin
          time_dig[entry_pos] = entry_value(entry_pos, beat.key_code);
          entry_pos = entry_pos + 2'd1;
        end
        if (alarm_mode) begin
          alarm_dig[entry_pos] = entry_value(entry_pos, beat.key_code);
          entry_pos = entry_pos + 2'd1;
        end
      end
    end

    // the clock only runs outside both setting modes, one second per beat at most
    if (!time_mode && !alarm_mode && tick_cnt >= thresh) begin
      tick_cnt = '0;
      time_dig[3] = time_dig[3] + 4'd1;
      if (time_dig[3] > UNITS_MAX) begin
        time_dig[3] = '0;
        time_dig[2] = time_dig[2] + 4'd1;
        if (time_dig[2] > {1'b0, TENS_MAX}) begin
          time_dig[2] = '0;
          time_dig[1] = time_dig[1] + 4'd1;
          if (time_dig[1] > UNITS_MAX) begin
            time_dig[1] = '0;
            time_dig[0] = time_dig[0] + 4'd1;
            // minutes tens wraps too: 99:59 rolls over to 00:00
            if (time_dig[0] > UNITS_MAX) begin
              time_dig[0] = '0;
            end
          end
        end
      end
    end

    // alarm digits are shown only while the alarm alone is being set
    if (alarm_mode && !time_mode) begin
      shown = alarm_dig;
    end else begin
      shown = time_dig;
    end
    r.shown.d0 = shown[0];
    r.shown.d1 = shown[1];
    r.shown.d2 = shown[2][2:0];
    r.shown.d3 = shown[3];
    r.time_setting_on = time_mode;
    r.alarm_setting_on = alarm_mode;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int pick_pause(bit steady);
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // command driver: presents beats from beat_q on the falling edge
  // ---------------------------------------------------------------------------
  int send_pause = 0;
  bit send_steady = 1'b0;
  bit cmd_took = 1'b0;  // a command beat was taken at the last rising edge

  always @(negedge clk) begin : drive_cmd
    item_t nxt;
    logic  nxt_valid;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_took) begin
      nxt_valid = 1'b0;
      if (send_pause > 0) begin
        send_pause--;
      end else if (beat_q.size() > 0) begin
        nxt = beat_q.pop_front();
        nxt_valid = 1'b1;
        cmd_if.opcode <= nxt.opcode;
        cmd_if.key_code <= nxt.key_code;
        // now and then switch between idling and a stretch with no gaps
        if ($urandom_range(0, 63) == 0) begin
          send_steady = !send_steady;
        end
        send_pause = pick_pause(send_steady);
      end
      cmd_if.valid <= nxt_valid;
    end
  end

  // display side back-pressure
  int recv_pause = 0;
  bit recv_steady = 1'b0;

  always @(negedge clk) begin : drive_disp_ready
    if (rst) begin
      disp_if.ready <= 1'b0;
    end else if (recv_pause > 0) begin
      recv_pause--;
      disp_if.ready <= 1'b0;
    end else begin
      disp_if.ready <= 1'b1;
      if ($urandom_range(0, 63) == 0) begin
        recv_steady = !recv_steady;
      end
      recv_pause = pick_pause(recv_steady);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every command beat, checks every display beat,
  // and ends the run if nothing moves for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : watch
    item_t   seen;
    result_t due;
    bit      moved;
    moved = 1'b0;
    cmd_took <= !rst && cmd_if.valid && cmd_if.ready;
    if (!rst) begin
      if (cfg_wr_en) begin
        thresh = cfg_wr_data;
        moved = 1'b1;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        seen.opcode = cmd_if.opcode;
        seen.key_code = cmd_if.key_code;
        display_due_q.push_back(step_clock(seen));
        moved = 1'b1;
      end
      if (disp_if.valid && disp_if.ready) begin
        moved = 1'b1;
        if (display_due_q.size() == 0) begin
          $display("%0t: display beat with none due, expected nothing actual %h_%h_%h_%h %b%b",
                   $time, disp_if.shown_digit_0, disp_if.shown_digit_1, disp_if.shown_digit_2,
                   disp_if.shown_digit_3, disp_if.time_setting_on, disp_if.alarm_setting_on);
          mismatches++;
        end else begin
          due = display_due_q.pop_front();
          results_checked++;
          check_field("minutes tens", due.shown.d0, disp_if.shown_digit_0);
          check_field("minutes units", due.shown.d1, disp_if.shown_digit_1);
          check_field("seconds tens", due.shown.d2, disp_if.shown_digit_2);
          check_field("seconds units", due.shown.d3, disp_if.shown_digit_3);
          check_field("time setting", due.time_setting_on, disp_if.time_setting_on);
          check_field("alarm setting", due.alarm_setting_on, disp_if.alarm_setting_on);
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_beat(logic op, logic [KEY_W-1:0] key);
    item_t b;
    b.opcode = op;
    b.key_code = key;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  // key_code is don't-care on ticks, so it carries noise
  task automatic push_ticks(int n);
    repeat (n) push_beat(OP_TICK, KEY_W'($urandom_range(0, 15)));
  endtask

  // digits keyed during setting, with ticks sometimes slipping in between
  task automatic push_digits(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        push_ticks($urandom_range(1, 4));
      end
      push_beat(OP_KEY, KEY_W'($urandom_range(0, 9)));
    end
  endtask

  // mostly well-formed setting sessions and tick bursts, some raw noise
  task automatic push_random_phase(int n);
    int start;
    int pick;
    start = beats_queued;
    while (beats_queued - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_ticks($urandom_range(1, 12));
      end else if (pick < 62) begin
        push_beat(OP_KEY, KEY_TIME_ON);
        push_digits($urandom_range(1, 6));
        push_beat(OP_KEY, KEY_TIME_OFF);
      end else if (pick < 78) begin
        push_beat(OP_KEY, KEY_ALARM_ON);
        push_digits($urandom_range(1, 6));
        push_beat(OP_KEY, KEY_ALARM_OFF);
      end else if (pick < 88) begin
        // both modes on at once, entered and left in either order
        if ($urandom_range(0, 1)) begin
          push_beat(OP_KEY, KEY_TIME_ON);
          push_beat(OP_KEY, KEY_ALARM_ON);
        end else begin
          push_beat(OP_KEY, KEY_ALARM_ON);
          push_beat(OP_KEY, KEY_TIME_ON);
        end
        push_digits($urandom_range(1, 5));
        if ($urandom_range(0, 1)) begin
          push_beat(OP_KEY, KEY_TIME_OFF);
          push_ticks($urandom_range(0, 2));
          push_beat(OP_KEY, KEY_ALARM_OFF);
        end else begin
          push_beat(OP_KEY, KEY_ALARM_OFF);
          push_ticks($urandom_range(0, 2));
          push_beat(OP_KEY, KEY_TIME_OFF);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_beat(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 15)));
        end
      end
    end
  endtask

  // threshold writes only happen with nothing in flight
  task automatic set_threshold(logic [TICK_W-1:0] v);
    while (results_checked != beats_queued) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic [TICK_W-1:0] th;
    cmd_if.valid = 1'b0;
    cmd_if.opcode = OP_TICK;
    cmd_if.key_code = '0;
    disp_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one tick per second so every carry shows at once
    set_threshold(16'd1);
    push_beat(OP_TICK, KEY_SPARE_B);  // 00:01
    push_beat(OP_KEY, KEY_TIME_ON);
    push_beat(OP_KEY, 4'd9);          // minutes tens
    push_beat(OP_KEY, 4'd9);          // same key again, dropped
    push_beat(OP_KEY, KEY_SPARE_A);   // breaks the repeat, no other effect
    push_beat(OP_KEY, 4'd9);          // minutes units
    push_beat(OP_KEY, 4'd7);          // seconds tens, clamps to 5
    push_beat(OP_KEY, 4'd9);          // seconds units, now 99:59
    push_beat(OP_TICK, 4'd0);         // counted while setting, clock held
    push_beat(OP_KEY, KEY_TIME_OFF);  // leaving setting rolls 99:59 over to 00:00
    push_beat(OP_KEY, KEY_ALARM_ON);  // display switches to alarm digits
    push_beat(OP_KEY, 4'd5);
    push_beat(OP_KEY, KEY_TIME_ON);   // both modes: one key fills two slots
    push_beat(OP_KEY, 4'd3);
    push_beat(OP_KEY, KEY_SPARE_B);
    push_beat(OP_KEY, 4'd0);
    push_beat(OP_KEY, KEY_ALARM_OFF);
    push_beat(OP_KEY, KEY_TIME_OFF);
    push_beat(OP_TICK, 4'd0);
    push_beat(OP_KEY, KEY_TIME_OFF);  // repeat of the last key

    // zero threshold: every beat outside setting advances the clock
    set_threshold('0);
    push_beat(OP_KEY, 4'd8);
    push_beat(OP_TICK, 4'd0);
    push_beat(OP_TICK, 4'd0);
    push_beat(OP_KEY, KEY_ALARM_ON);
    push_beat(OP_KEY, KEY_ALARM_OFF);

    // largest threshold; ticks keep counting while time setting holds the clock,
    // but stay far below it, so leaving setting does not advance
    set_threshold('1);
    push_beat(OP_KEY, KEY_SPARE_B);
    push_beat(OP_KEY, KEY_TIME_ON);
    push_ticks(HELD_TICKS);
    push_beat(OP_KEY, KEY_TIME_OFF);
    push_ticks(3);

    // random phases over a spread of thresholds, mostly small ones
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       th = 16'd2;
        1:       th = 16'd1;
        2:       th = 16'd3;
        3:       th = TPS_RESET;
        4:       th = TICK_W'($urandom_range(4, 9));
        5:       th = TICK_W'($urandom_range(100, 4000));
        default: th = TICK_W'($urandom_range(1, 6));
      endcase
      set_threshold(th);
      push_random_phase(BEATS_PER_PHASE);
    end

    // drain, then give the two-stage pipe time to show anything stray
    while (results_checked != beats_queued) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
